// File: rtl/blse_pkg.sv
package blse_pkg;

  localparam int DATA_W   = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SORT   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef logic [DATA_W-1:0]   data_t;
  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [COUNT_W-1:0]  count_t;

endpackage

// File: rtl/blse_in_if.sv
interface blse_in_if
  import blse_pkg::*;
  ;
  logic    valid;
  logic    ready;
  action_t action;
  data_t   value;
  logic    sort_ascending;

  modport source (output valid, output action, output value, output sort_ascending,
                  input ready);
  modport sink (input valid, input action, input value, input sort_ascending,
                output ready);
endinterface

// File: rtl/blse_out_if.sv
interface blse_out_if
  import blse_pkg::*;
  ;
  logic    valid;
  logic    ready;
  status_t status;
  data_t   result_value;
  count_t  item_count;
  data_t   min_value;
  data_t   max_value;
  logic    all_even;

  modport source (output valid, output status, output result_value, output item_count,
                  output min_value, output max_value, output all_even, input ready);
  modport sink (input valid, input status, input result_value, input item_count,
                input min_value, input max_value, input all_even, output ready);
endinterface

// File: rtl/blse_ram.sv
module blse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bounded_list_store_engine.sv
// Bounded list of up to LIST_DEPTH signed 32-bit values held in one single-port-read RAM.
// One command is worked at a time; the next is taken once the previous result sits in the
// output register. Every command ends with a walk over the stored entries for minimum,
// maximum and parity, which also finds the first match for a find; a remove first reads
// the removed entry in S_REM and S_REM_CAP. Sort is an exchange sort through the same RAM
// read port, run before that walk. item_count wraps modulo 64.
module bounded_list_store_engine
  import blse_pkg::*;
#(
  parameter int LIST_DEPTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  blse_in_if.sink   in_ch,
  blse_out_if.source out_ch
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
  localparam logic [CNT_W:0] TWO_CNT = (CNT_W + 1)'(2);
  localparam count_t DEPTH_MASKED = COUNT_W'(LIST_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_REM, S_REM_CAP, S_LOAD, S_LOADA, S_INNER, S_WB, S_SCAN, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  action_t         act_r, act_nxt;
  data_t           value_r, value_nxt;
  logic            asc_r, asc_nxt;
  status_t         status_r, status_nxt;
  data_t           result_r, result_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] jd_r, jd_nxt;
  logic            pend_r, pend_nxt;
  data_t           a_r, a_nxt;
  data_t           lo_r, lo_nxt;
  data_t           hi_r, hi_nxt;
  logic            even_r, even_nxt;
  logic            found_r, found_nxt;

  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  data_t           out_result_r, out_result_nxt;
  count_t          out_count_r, out_count_nxt;
  data_t           out_min_r, out_min_nxt;
  data_t           out_max_r, out_max_nxt;
  logic            out_even_r, out_even_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  data_t            ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  data_t            ram_rdata;

  logic             in_acc;
  logic             do_swap;
  logic [CNT_W+5:0] count_ext;

  blse_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign do_swap = asc_r ? ($signed(ram_rdata) < $signed(a_r))
                         : ($signed(a_r) < $signed(ram_rdata));
  assign count_ext = {6'b0, count_r};

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    act_nxt = act_r;
    value_nxt = value_r;
    asc_nxt = asc_r;
    status_nxt = status_r;
    result_nxt = result_r;
    i_nxt = i_r;
    j_nxt = j_r;
    jd_nxt = jd_r;
    pend_nxt = pend_r;
    a_nxt = a_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    even_nxt = even_r;
    found_nxt = found_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_result_nxt = out_result_r;
    out_count_nxt = out_count_r;
    out_min_nxt = out_min_r;
    out_max_nxt = out_max_r;
    out_even_nxt = out_even_r;
    ram_we = 1'b0;
    ram_waddr = i_r[IDX_W-1:0];
    ram_wdata = a_r;
    ram_raddr = j_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt = in_ch.action;
          value_nxt = in_ch.value;
          asc_nxt = in_ch.sort_ascending;
          status_nxt = ST_OK;
          result_nxt = '0;
          found_nxt = 1'b0;
          lo_nxt = '0;
          hi_nxt = '0;
          even_nxt = 1'b1;
          j_nxt = '0;
          pend_nxt = 1'b0;
          state_nxt = S_SCAN;
          case (in_ch.action)
            ACT_CLEAR: begin
              count_nxt = '0;
            end
            ACT_APPEND: begin
              if (count_r >= DEPTH_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we = 1'b1;
                ram_waddr = count_r[IDX_W-1:0];
                ram_wdata = in_ch.value;
                count_nxt = count_r + ONE_CNT;
              end
            end
            ACT_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - ONE_CNT;
                state_nxt = S_REM;
              end
            end
            ACT_FIND: begin
              status_nxt = ST_NOT_FOUND;
            end
            ACT_SORT: begin
              if (count_r >= CNT_W'(2)) begin
                i_nxt = '0;
                state_nxt = S_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REM: begin
        ram_raddr = count_r[IDX_W-1:0];
        state_nxt = S_REM_CAP;
      end
      S_REM_CAP: begin
        result_nxt = ram_rdata;
        state_nxt = S_SCAN;
      end
      S_LOAD: begin
        ram_raddr = i_r[IDX_W-1:0];
        j_nxt = i_r + ONE_CNT;
        state_nxt = S_LOADA;
      end
      S_LOADA: begin
        a_nxt = ram_rdata;
        ram_raddr = j_r[IDX_W-1:0];
        jd_nxt = j_r;
        j_nxt = j_r + ONE_CNT;
        pend_nxt = 1'b1;
        state_nxt = S_INNER;
      end
      S_INNER: begin
        if (pend_r) begin
          if (do_swap) begin
            ram_we = 1'b1;
            ram_waddr = jd_r[IDX_W-1:0];
            ram_wdata = a_r;
            a_nxt = ram_rdata;
          end
          if (j_r < count_r) begin
            ram_raddr = j_r[IDX_W-1:0];
            jd_nxt = j_r;
            j_nxt = j_r + ONE_CNT;
            pend_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b0;
          end
        end else begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        ram_we = 1'b1;
        ram_waddr = i_r[IDX_W-1:0];
        ram_wdata = a_r;
        if (({1'b0, i_r} + TWO_CNT) < {1'b0, count_r}) begin
          i_nxt = i_r + ONE_CNT;
          state_nxt = S_LOAD;
        end else begin
          j_nxt = '0;
          pend_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pend_r) begin
          if (jd_r == '0) begin
            lo_nxt = ram_rdata;
            hi_nxt = ram_rdata;
          end else begin
            if ($signed(ram_rdata) < $signed(lo_r)) begin
              lo_nxt = ram_rdata;
            end
            if ($signed(hi_r) < $signed(ram_rdata)) begin
              hi_nxt = ram_rdata;
            end
          end
          if (ram_rdata[0]) begin
            even_nxt = 1'b0;
          end
          if (act_r == ACT_FIND && !found_r && ram_rdata == value_r) begin
            found_nxt = 1'b1;
            status_nxt = ST_OK;
            result_nxt = DATA_W'(jd_r);
          end
        end
        if (j_r < count_r) begin
          ram_raddr = j_r[IDX_W-1:0];
          jd_nxt = j_r;
          j_nxt = j_r + ONE_CNT;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_result_nxt = result_r;
          out_count_nxt = count_ext[COUNT_W-1:0];
          out_min_nxt = lo_r;
          out_max_nxt = hi_r;
          out_even_nxt = even_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r <= act_nxt;
    value_r <= value_nxt;
    asc_r <= asc_nxt;
    status_r <= status_nxt;
    result_r <= result_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    jd_r <= jd_nxt;
    a_r <= a_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    even_r <= even_nxt;
    found_r <= found_nxt;
    out_status_r <= out_status_nxt;
    out_result_r <= out_result_nxt;
    out_count_r <= out_count_nxt;
    out_min_r <= out_min_nxt;
    out_max_r <= out_max_nxt;
    out_even_r <= out_even_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.result_value = out_result_r;
  assign out_ch.item_count = out_count_r;
  assign out_ch.min_value = out_min_r;
  assign out_ch.max_value = out_max_r;
  assign out_ch.all_even = out_even_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("stored count exceeds list depth");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == S_IDLE && !in_acc && ram_we))
    else $error("list write without a command in progress");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_FULL |-> out_ch.item_count == DEPTH_MASKED)
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_EMPTY |-> out_ch.item_count == '0)
    else $error("empty status with stored values");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $signed(out_ch.min_value) <= $signed(out_ch.max_value))
    else $error("minimum above maximum");

endmodule

// File: test/tb_bounded_list_store_engine.sv
`timescale 1ns / 1ps

module tb_bounded_list_store_engine
  import blse_pkg::*;
  ;

  localparam int LIST_DEPTH  = 32;
  localparam int ITEM_TARGET = 1150;
  localparam int IDLE_LIMIT  = 6000;
  localparam int HOLD_CYCLES = 300;

  localparam action_t ACT_RSVD5 = 3'd5;
  localparam action_t ACT_RSVD6 = 3'd6;
  localparam action_t ACT_RSVD7 = 3'd7;

  localparam data_t VAL_MIN  = 32'h8000_0000;
  localparam data_t VAL_MAX  = 32'h7fff_ffff;
  localparam data_t VAL_NEG1 = 32'hffff_ffff;

  typedef struct packed {
    status_t status;
    data_t   result_value;
    count_t  item_count;
    data_t   min_value;
    data_t   max_value;
    logic    all_even;
  } list_report_t;

  logic clk;
  logic rst_n;

  blse_in_if  in_ch ();
  blse_out_if out_ch ();

  bounded_list_store_engine #(.LIST_DEPTH(LIST_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  data_t        list_mem [LIST_DEPTH];
  int           list_len;
  list_report_t expected_reports [$];
  int           error_count;
  int           items_sent;
  bit           no_gaps;
  int           hold_request;
  int           rx_stall_left;
  int           idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  function automatic list_report_t apply_command(action_t act, data_t val, logic asc);
    list_report_t rpt;
    data_t        a;
    data_t        b;
    int           i;
    int           j;
    rpt = '0;
    rpt.status = ST_OK;
    rpt.all_even = 1'b1;
    case (act)
      ACT_CLEAR: list_len = 0;
      ACT_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          rpt.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      ACT_REMOVE: begin
        if (list_len == 0) begin
          rpt.status = ST_EMPTY;
        end else begin
          list_len--;
          rpt.result_value = list_mem[list_len];
        end
      end
      ACT_FIND: begin
        rpt.status = ST_NOT_FOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) begin
            rpt.status = ST_OK;
            rpt.result_value = data_t'(i);
            break;
          end
        end
      end
      ACT_SORT: begin
        for (i = 0; i < list_len; i++) begin
          for (j = i + 1; j < list_len; j++) begin
            a = list_mem[i];
            b = list_mem[j];
            if (asc ? ($signed(b) < $signed(a)) : ($signed(a) < $signed(b))) begin
              list_mem[i] = b;
              list_mem[j] = a;
            end
          end
        end
      end
      default: ;
    endcase
    for (i = 0; i < list_len; i++) begin
      if (i == 0 || $signed(list_mem[i]) < $signed(rpt.min_value)) rpt.min_value = list_mem[i];
      if (i == 0 || $signed(list_mem[i]) > $signed(rpt.max_value)) rpt.max_value = list_mem[i];
      if (list_mem[i][0]) rpt.all_even = 1'b0;
    end
    rpt.item_count = count_t'(list_len);
    return rpt;
  endfunction

  function automatic data_t rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 7) return data_t'($urandom_range(0, 16) - 8);
    if (r == 7) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_NEG1;
        default: return '0;
      endcase
    end
    if (list_len > 0) return list_mem[$urandom_range(0, list_len - 1)];
    return $urandom;
  endfunction

  task automatic send_cmd(action_t act, data_t val, logic asc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= act;
    in_ch.value          <= val;
    in_ch.sort_ascending <= asc;
    do @(posedge clk); while (!in_ch.ready);
    expected_reports.push_back(apply_command(act, val, asc));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_report();
    list_report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: unexpected item, status %0d count %0d", $time, out_ch.status,
               out_ch.item_count);
      error_count++;
      return;
    end
    want = expected_reports.pop_front();
    check_field("status", 32'(want.status), 32'(out_ch.status));
    check_field("result_value", want.result_value, out_ch.result_value);
    check_field("item_count", 32'(want.item_count), 32'(out_ch.item_count));
    check_field("min_value", want.min_value, out_ch.min_value);
    check_field("max_value", want.max_value, out_ch.max_value);
    check_field("all_even", 32'(want.all_even), 32'(out_ch.all_even));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_report();
      if (hold_request > 0) begin
        rx_stall_left = hold_request;
        hold_request = 0;
      end
      if (rx_stall_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_bounded_list_store_engine: FAIL");
        $finish;
      end
    end
  end

  task automatic test_empty_list();
    send_cmd(ACT_REMOVE, VAL_NEG1, 1'b0);
    send_cmd(ACT_FIND, '0, 1'b0);
    send_cmd(ACT_SORT, VAL_MAX, 1'b1);
    send_cmd(ACT_SORT, VAL_MIN, 1'b0);
    send_cmd(ACT_RSVD5, VAL_MAX, 1'b1);
    send_cmd(ACT_RSVD6, VAL_MIN, 1'b0);
    send_cmd(ACT_RSVD7, VAL_NEG1, 1'b1);
    send_cmd(ACT_CLEAR, VAL_NEG1, 1'b1);
  endtask

  task automatic test_extremes();
    send_cmd(ACT_APPEND, data_t'(7), 1'b0);
    send_cmd(ACT_SORT, '0, 1'b1);
    send_cmd(ACT_FIND, data_t'(7), 1'b0);
    send_cmd(ACT_APPEND, VAL_MAX, 1'b0);
    send_cmd(ACT_APPEND, VAL_MIN, 1'b0);
    send_cmd(ACT_APPEND, VAL_NEG1, 1'b0);
    send_cmd(ACT_APPEND, '0, 1'b0);
    send_cmd(ACT_APPEND, VAL_MAX, 1'b0);
    send_cmd(ACT_FIND, VAL_MAX, 1'b0);
    send_cmd(ACT_FIND, data_t'(12345), 1'b0);
    send_cmd(ACT_SORT, '0, 1'b0);
    send_cmd(ACT_FIND, VAL_MIN, 1'b0);
    send_cmd(ACT_SORT, '0, 1'b1);
    send_cmd(ACT_REMOVE, '0, 1'b0);
    send_cmd(ACT_REMOVE, '0, 1'b0);
    send_cmd(ACT_CLEAR, '0, 1'b0);
  endtask

  task automatic test_full_list();
    int k;
    send_cmd(ACT_CLEAR, $urandom, 1'b0);
    for (k = 0; k < LIST_DEPTH; k++) send_cmd(ACT_APPEND, rand_value(), 1'($urandom_range(0, 1)));
    send_cmd(ACT_APPEND, rand_value(), 1'b0);
    send_cmd(ACT_APPEND, VAL_MAX, 1'b1);
    send_cmd(ACT_FIND, list_mem[LIST_DEPTH - 1], 1'b0);
    send_cmd(ACT_SORT, $urandom, 1'b1);
    send_cmd(ACT_FIND, list_mem[$urandom_range(0, LIST_DEPTH - 1)], 1'b0);
    send_cmd(ACT_SORT, $urandom, 1'b0);
    for (k = 0; k <= LIST_DEPTH; k++) send_cmd(ACT_REMOVE, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_backpressure();
    int k;
    wait_drained();
    no_gaps = 1'b1;
    hold_request = HOLD_CYCLES;
    for (k = 0; k < 20; k++) send_cmd(ACT_APPEND, rand_value(), 1'b1);
    send_cmd(ACT_SORT, '0, 1'b0);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_mix();
    int     burst;
    int     k;
    int     r;
    data_t  val;
    while (items_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0) send_cmd(ACT_CLEAR, $urandom, 1'($urandom_range(0, 1)));
      burst = $urandom_range(5, 40);
      for (k = 0; k < burst; k++) begin
        r = $urandom_range(0, 99);
        val = rand_value();
        if (r < 40) begin
          send_cmd(ACT_APPEND, val, 1'($urandom_range(0, 1)));
        end else if (r < 55) begin
          send_cmd(ACT_REMOVE, val, 1'($urandom_range(0, 1)));
        end else if (r < 75) begin
          if (list_len > 0 && $urandom_range(0, 1)) val = list_mem[$urandom_range(0, list_len - 1)];
          send_cmd(ACT_FIND, val, 1'($urandom_range(0, 1)));
        end else if (r < 85) begin
          send_cmd(ACT_SORT, val, 1'($urandom_range(0, 1)));
        end else if (r < 90) begin
          send_cmd(ACT_CLEAR, val, 1'($urandom_range(0, 1)));
        end else if (r < 95) begin
          send_cmd(action_t'(ACT_SORT + $urandom_range(1, 3)), val, 1'($urandom_range(0, 1)));
        end else begin
          send_cmd(ACT_APPEND, val, 1'($urandom_range(0, 1)));
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    error_count = 0;
    items_sent = 0;
    list_len = 0;
    no_gaps = 1'b0;
    hold_request = 0;
    rx_stall_left = 0;
    idle_cycles = 0;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= ACT_CLEAR;
    in_ch.value          <= '0;
    in_ch.sort_ascending <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_extremes();
    test_full_list();
    test_backpressure();
    test_random_mix();
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("tb_bounded_list_store_engine: PASS");
    end else begin
      $display("tb_bounded_list_store_engine: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/blse_pkg.sv
rtl/blse_in_if.sv
rtl/blse_out_if.sv
rtl/blse_ram.sv
rtl/bounded_list_store_engine.sv
test/tb_bounded_list_store_engine.sv
